// ===== rtl/obbc_pkg.sv =====
package obbc_pkg;

   localparam int OPERAND_BITS = 8;
   localparam int DATA_W = 8;
   localparam int ENTRY_BIT_W = 3;
   localparam int OP_W = 3;
   localparam int OP_COUNT = 6;
   localparam int IDX_W = $clog2(OPERAND_BITS + 1);
   localparam int STEP_CNT_W = $clog2(DATA_W);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [DATA_W-1:0] LONG_PRESS_RESET = 8'd42;
   localparam logic [DATA_W-1:0] BLINK_PERIOD_RESET = 8'd72;

   typedef enum logic [0:0] {
      CSR_LONG_PRESS   = 1'b0,
      CSR_BLINK_PERIOD = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_WAIT,
      PH_HOLD,
      PH_RELEASE
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE,
      EV_SHORT,
      EV_LONG
   } event_type;

   typedef enum logic [OP_W-1:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_AND = 3'd4,
      OP_OR  = 3'd5
   } op_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_CALC
   } back_state_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } alu_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] result;
   } alu_rsp_type;

endpackage

// ===== rtl/obbc_front.sv =====
module obbc_front
   import obbc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_button_down,
   output logic              req_stall,
   input  logic [DATA_W-1:0] long_press_frames,
   input  logic              q_full,
   output logic              push,
   output event_type         push_event
);

   phase_type         phase_ff, phase_in;
   logic [DATA_W-1:0] hold_ff, hold_in;
   logic [DATA_W-1:0] hold_next;
   logic [DATA_W-1:0] limit;
   logic              accept;

   assign accept    = req_valid && !q_full;
   assign req_stall = q_full;
   assign push      = accept;
   assign limit     = (long_press_frames == '0) ? DATA_W'(1) : long_press_frames;
   assign hold_next = hold_ff + DATA_W'(1);

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_WAIT: begin
            if (req_button_down) phase_in = PH_HOLD;
         end
         PH_HOLD: begin
            if (!req_button_down) phase_in = PH_WAIT;
            else if (hold_next >= limit) phase_in = PH_RELEASE;
         end
         PH_RELEASE: begin
            if (!req_button_down) phase_in = PH_WAIT;
         end
         default: phase_in = PH_WAIT;
      endcase
   end

   always_comb begin
      push_event = EV_NONE;
      hold_in    = hold_ff;
      unique case (phase_ff)
         PH_WAIT: begin
            if (req_button_down) hold_in = '0;
         end
         PH_HOLD: begin
            if (!req_button_down) begin
               push_event = EV_SHORT;
            end else begin
               hold_in = hold_next;
               if (hold_next >= limit) push_event = EV_LONG;
            end
         end
         PH_RELEASE: begin
            push_event = EV_NONE;
         end
         default: push_event = EV_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         hold_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         hold_ff  <= hold_in;
      end
   end

endmodule

// ===== rtl/obbc_queue.sv =====
module obbc_queue
   import obbc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  event_type push_event,
   input  logic      pop,
   output logic      full,
   output logic      empty,
   output event_type head
);

   event_type          entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) count_in = count_ff + QCNT_W'(1);
      else if (pop && !push) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_event;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/obbc_alu.sv =====
module obbc_alu
   import obbc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  alu_req_type       req,
   input  logic [DATA_W-1:0] a,
   input  logic [DATA_W-1:0] b,
   output alu_rsp_type       rsp
);

   logic                  busy_ff, busy_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  is_div_ff, is_div_in;
   logic                  neg_ff, neg_in;
   logic [DATA_W-1:0]     x_ff, x_in;
   logic [DATA_W-1:0]     y_ff, y_in;
   logic [DATA_W-1:0]     p_ff, p_in;

   logic [DATA_W-1:0]     p_mstep, x_mstep, y_mstep;
   logic [DATA_W:0]       rem_sh, rem_next;
   logic                  ge;
   logic [DATA_W-1:0]     p_dstep, x_dstep;
   logic [DATA_W-1:0]     mag_a, mag_b;
   logic                  last_step;

   // One bit of the multiplier or one quotient bit per cycle.
   assign p_mstep  = y_ff[0] ? p_ff + x_ff : p_ff;
   assign x_mstep  = {x_ff[DATA_W-2:0], 1'b0};
   assign y_mstep  = {1'b0, y_ff[DATA_W-1:1]};

   assign rem_sh   = {p_ff, x_ff[DATA_W-1]};
   assign ge       = (rem_sh >= {1'b0, y_ff});
   assign rem_next = ge ? rem_sh - {1'b0, y_ff} : rem_sh;
   assign p_dstep  = rem_next[DATA_W-1:0];
   assign x_dstep  = {x_ff[DATA_W-2:0], ge};

   assign mag_a    = a[DATA_W-1] ? DATA_W'(-a) : a;
   assign mag_b    = b[DATA_W-1] ? DATA_W'(-b) : b;

   assign last_step  = busy_ff && (cnt_ff == STEP_CNT_W'(DATA_W - 1));
   assign rsp.done   = last_step;
   assign rsp.result = is_div_ff ? (neg_ff ? DATA_W'(-x_dstep) : x_dstep) : p_mstep;

   always_comb begin
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      is_div_in = is_div_ff;
      neg_in    = neg_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      p_in      = p_ff;
      if (req.start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         is_div_in = req.is_div;
         neg_in    = a[DATA_W-1] ^ b[DATA_W-1];
         x_in      = req.is_div ? mag_a : a;
         y_in      = req.is_div ? mag_b : b;
         p_in      = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + STEP_CNT_W'(1);
         if (last_step) busy_in = 1'b0;
         if (is_div_ff) begin
            x_in = x_dstep;
            p_in = p_dstep;
         end else begin
            x_in = x_mstep;
            y_in = y_mstep;
            p_in = p_mstep;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      is_div_ff <= is_div_in;
      neg_ff    <= neg_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      p_ff      <= p_in;
   end

endmodule

// ===== rtl/obbc_back.sv =====
module obbc_back
   import obbc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  event_type              q_head,
   output logic                   q_pop,
   input  logic [DATA_W-1:0]      blink_period_frames,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [DATA_W-1:0] rsp_accumulator,
   output logic [DATA_W-1:0]      rsp_operand,
   output logic [ENTRY_BIT_W-1:0] rsp_entry_bit,
   output logic                   rsp_entry_done,
   output logic [OP_W-1:0]        rsp_operation,
   output logic                   rsp_blink
);

   back_state_type    state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] operand_ff, operand_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              done_ff, done_in;
   op_type            op_ff, op_in;
   logic [DATA_W-1:0] blink_cnt_ff, blink_cnt_in;
   logic              blink_ff, blink_in;

   logic              out_free;
   logic              needs_alu;
   logic              finish;
   logic [DATA_W:0]   blink_next;
   logic [OP_W:0]     op_plus;
   logic [IDX_W-1:0]  idx_plus;
   logic [DATA_W-1:0] direct_acc;
   alu_req_type       alu_req;
   alu_rsp_type       alu_rsp;

   obbc_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .a     (acc_ff),
      .b     (operand_ff),
      .rsp   (alu_rsp)
   );

   assign out_free   = !(rsp_valid_ff && rsp_stall);
   assign needs_alu  = (q_head == EV_LONG) && done_ff &&
                       ((op_ff == OP_MUL) || ((op_ff == OP_DIV) && (operand_ff != '0)));
   assign finish     = (state_ff == BACK_CALC) && alu_rsp.done;
   assign blink_next = {1'b0, blink_cnt_ff} + (DATA_W + 1)'(1);
   assign op_plus    = {1'b0, op_ff} + (OP_W + 1)'(1);
   assign idx_plus   = idx_ff + IDX_W'(1);

   always_comb begin
      unique case (op_ff)
         OP_ADD:  direct_acc = acc_ff + operand_ff;
         OP_SUB:  direct_acc = acc_ff - operand_ff;
         OP_AND:  direct_acc = acc_ff & operand_ff;
         OP_OR:   direct_acc = acc_ff | operand_ff;
         default: direct_acc = acc_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (q_pop && needs_alu) state_in = BACK_CALC;
         end
         BACK_CALC: begin
            if (alu_rsp.done) state_in = BACK_IDLE;
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      q_pop          = (state_ff == BACK_IDLE) && !q_empty && out_free;
      alu_req.start  = q_pop && needs_alu;
      alu_req.is_div = (op_ff == OP_DIV);
      rsp_valid_in   = rsp_valid_ff;
      if ((q_pop && !needs_alu) || finish) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_comb begin
      acc_in       = acc_ff;
      operand_in   = operand_ff;
      idx_in       = idx_ff;
      done_in      = done_ff;
      op_in        = op_ff;
      blink_cnt_in = blink_cnt_ff;
      blink_in     = blink_ff;
      if (q_pop) begin
         if (blink_next >= {1'b0, blink_period_frames}) begin
            blink_cnt_in = '0;
            blink_in     = !blink_ff;
         end else begin
            blink_cnt_in = blink_next[DATA_W-1:0];
         end
         if (q_head != EV_NONE) begin
            if (done_ff) begin
               if (q_head == EV_LONG) begin
                  if (!needs_alu) acc_in = direct_acc;
                  operand_in = '0;
                  done_in    = 1'b0;
               end else begin
                  op_in = (op_plus >= (OP_W + 1)'(OP_COUNT)) ? OP_ADD :
                          op_type'(op_plus[OP_W-1:0]);
               end
            end else begin
               if ((q_head == EV_LONG) && (idx_ff < IDX_W'(DATA_W))) begin
                  operand_in[idx_ff[ENTRY_BIT_W-1:0]] = 1'b1;
               end
               idx_in = idx_plus;
               if (idx_plus >= IDX_W'(OPERAND_BITS)) begin
                  done_in      = 1'b1;
                  idx_in       = '0;
                  blink_in     = 1'b1;
                  blink_cnt_in = DATA_W'(1);
               end
            end
         end
      end
      if (finish) acc_in = alu_rsp.result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         operand_ff   <= '0;
         idx_ff       <= '0;
         done_ff      <= 1'b0;
         op_ff        <= OP_ADD;
         blink_cnt_ff <= DATA_W'(1);
         blink_ff     <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         operand_ff   <= operand_in;
         idx_ff       <= idx_in;
         done_ff      <= done_in;
         op_ff        <= op_in;
         blink_cnt_ff <= blink_cnt_in;
         blink_ff     <= blink_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accumulator = acc_ff;
   assign rsp_operand     = operand_ff;
   assign rsp_entry_bit   = idx_ff[ENTRY_BIT_W-1:0];
   assign rsp_entry_done  = done_ff;
   assign rsp_operation   = op_ff;
   assign rsp_blink       = blink_ff;

endmodule

// ===== rtl/one_button_bit_entry_calculator_core.sv =====
// One-button calculator core, stepped once per display frame.
// Input channel (req_): one item per frame carrying the button level. The
// front end classifies presses as short or long and queues one event per item.
// Result channel (rsp_): exactly one item per input item, in order, showing the
// accumulator, operand, entry position, mode, selected operation and blink flag.
// Configuration: an APB-style port with the long-press frame count at address 0
// and the blink period at address 4; write them only while the block is idle.
// Flow: an item that needs no arithmetic passes through the event queue and then
// the registered rsp_valid, and with no stall such items can follow each other
// in every cycle. A long press in operation mode selecting multiply, or divide by
// a nonzero operand, uses the shared serial unit, which retires one bit per
// cycle; rsp_valid rises when that unit finishes, and the input side keeps
// accepting until the two-entry event queue fills.
// When rsp_stall is high the result item holds and the queue fills, after which
// req_stall rises. Synchronous reset empties the queue, drops rsp_valid, clears
// the calculator state and restores both configuration registers.
module one_button_bit_entry_calculator_core
   import obbc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_button_down,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_accumulator,
   output logic [DATA_W-1:0]        rsp_operand,
   output logic [ENTRY_BIT_W-1:0]   rsp_entry_bit,
   output logic                     rsp_entry_done,
   output logic [OP_W-1:0]          rsp_operation,
   output logic                     rsp_blink,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [CSR_DATA_W-1:0]    csr_pwdata,
   output logic [CSR_DATA_W-1:0]    csr_prdata,
   output logic                     csr_pready
);

   logic [DATA_W-1:0] long_press_ff, long_press_in;
   logic [DATA_W-1:0] blink_period_ff, blink_period_in;
   csr_index_type     csr_index;
   logic              csr_write;

   logic              q_full;
   logic              q_empty;
   logic              q_push;
   logic              q_pop;
   event_type         q_push_event;
   event_type         q_head;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      long_press_in   = long_press_ff;
      blink_period_in = blink_period_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_LONG_PRESS:   long_press_in   = csr_pwdata[DATA_W-1:0];
            CSR_BLINK_PERIOD: blink_period_in = csr_pwdata[DATA_W-1:0];
            default:          long_press_in   = long_press_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_LONG_PRESS:   csr_prdata = CSR_DATA_W'(long_press_ff);
         CSR_BLINK_PERIOD: csr_prdata = CSR_DATA_W'(blink_period_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff   <= LONG_PRESS_RESET;
         blink_period_ff <= BLINK_PERIOD_RESET;
      end else begin
         long_press_ff   <= long_press_in;
         blink_period_ff <= blink_period_in;
      end
   end

   obbc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_button_down   (req_button_down),
      .req_stall         (req_stall),
      .long_press_frames (long_press_ff),
      .q_full            (q_full),
      .push              (q_push),
      .push_event        (q_push_event)
   );

   obbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_event (q_push_event),
      .pop        (q_pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (q_head)
   );

   obbc_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_empty             (q_empty),
      .q_head              (q_head),
      .q_pop               (q_pop),
      .blink_period_frames (blink_period_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_accumulator     (rsp_accumulator),
      .rsp_operand         (rsp_operand),
      .rsp_entry_bit       (rsp_entry_bit),
      .rsp_entry_done      (rsp_entry_done),
      .rsp_operation       (rsp_operation),
      .rsp_blink           (rsp_blink)
   );

endmodule

// ===== rtl/obbc_checker.sv =====
module obbc_checker
   import obbc_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic signed [DATA_W-1:0] rsp_accumulator,
   input logic [ENTRY_BIT_W-1:0]   rsp_entry_bit,
   input logic                     rsp_entry_done,
   input logic [OP_W-1:0]          rsp_operation
);

   a_reset_clears_valid: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result valid or input stall after reset");

   a_done_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_done |-> rsp_entry_bit == '0)
      else $error("entry index not zero in operation mode");

   a_operation_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_operation != OP_W'(6)) && (rsp_operation != OP_W'(7)))
      else $error("operation code out of range");

   a_stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_accumulator))
      else $error("stalled result item changed");

endmodule

bind one_button_bit_entry_calculator_core obbc_checker u_obbc_checker (.*);
